// ===== src/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] task_tag;
    logic [7:0] task_priority;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_tag;
    logic [7:0] out_priority;
    logic       now_empty;
  } out_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic       valid;
    logic       keep;   // stays in place on an enqueue
    logic [7:0] prio;
    logic [7:0] tag;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       enq;
    logic       deq;
    logic [7:0] prio;
    logic [7:0] tag;
  } op_t;

endpackage
`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none
module spq_cell (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire spq_pkg::op_t    op_i,
  input  wire spq_pkg::entry_t left_i,
  input  wire spq_pkg::entry_t right_i,
  output spq_pkg::entry_t   cell_o
);
  import spq_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] prio_q, prio_d;
  logic [7:0] tag_q, tag_d;
  logic       keep;

  assign keep = valid_q && (prio_q >= op_i.prio);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    if (op_i.enq) begin
      valid_d = valid_q | left_i.valid;
      if (keep) begin
        prio_d = prio_q;
        tag_d  = tag_q;
      end else if (left_i.keep) begin
        // the new word lands right behind the last entry that stays
        prio_d = op_i.prio;
        tag_d  = op_i.tag;
      end else begin
        prio_d = left_i.prio;
        tag_d  = left_i.tag;
      end
    end else if (op_i.deq) begin
      valid_d = right_i.valid;
      prio_d  = right_i.prio;
      tag_d   = right_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign cell_o = '{valid: valid_q, keep: keep, prio: prio_q, tag: tag_q};

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
`default_nettype none
// channel   | ports                  | handshake
// ----------+------------------------+-------------------------------------
// command   | cmd_i (in_t)           | taken when start && !busy
// result    | res_o (out_t)          | valid while done_o is high
//
// One command per clock; the result shows up the cycle after acceptance.
// The store is a row of DEPTH cells compared in parallel against the new
// priority, so all cells update together on acceptance; busy stays low.
// Reset clears the valid bit of every cell; stored tags and priorities are
// not cleared. The result side has no stall: done_o flags each accepted command.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  wire spq_pkg::in_t cmd_i,
  output logic           done_o,
  output spq_pkg::out_t  res_o
);
  import spq_pkg::*;

  entry_t cells [DEPTH];
  entry_t lefts [DEPTH];
  entry_t rights[DEPTH];
  op_t    op;
  logic   accept, full, empty;
  logic   done_q;
  out_t   res_q, res_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = cells[DEPTH-1].valid;
  assign empty  = !cells[0].valid;

  assign op.enq  = accept && (cmd_i.func == FUNC_ENQ) && !full;
  assign op.deq  = accept && (cmd_i.func == FUNC_DEQ) && !empty;
  assign op.prio = cmd_i.task_priority;
  assign op.tag  = cmd_i.task_tag;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '{valid: 1'b1, keep: 1'b1, prio: 8'd0, tag: 8'd0};
    end else begin : g_mid
      assign lefts[i] = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rights[i] = '{valid: 1'b0, keep: 1'b0, prio: 8'd0, tag: 8'd0};
    end else begin : g_body
      assign rights[i] = cells[i+1];
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .left_i (lefts[i]),
      .right_i(rights[i]),
      .cell_o (cells[i])
    );
  end

  always_comb begin
    res_d = '{status: ST_OK, out_tag: 8'd0, out_priority: 8'd0, now_empty: empty};
    if (cmd_i.func == FUNC_ENQ) begin
      if (full) begin
        res_d.status = ST_FULL;
      end else begin
        res_d.now_empty = 1'b0;
      end
    end else begin
      if (empty) begin
        res_d.status = ST_EMPTY;
      end else begin
        res_d.out_tag      = cells[0].tag;
        res_d.out_priority = cells[0].prio;
        res_d.now_empty    = !cells[1].valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== bench/tb_sorted_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH = 16;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  cmd_i;
  logic done_o;
  out_t res_o;

  // shadow of the sorted store, slot 0 is the head
  logic [7:0] shadow_prio [DEPTH];
  logic [7:0] shadow_tag  [DEPTH];
  int         shadow_count;

  out_t pending_results[$];
  int   err_count;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one command to the shadow store, return the word it should produce
  function automatic out_t apply_command(in_t c);
    out_t r;
    int   pos;
    int   i;
    r = '0;
    if (c.func == FUNC_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // stable: go past every entry of equal or higher priority
        while (pos < shadow_count && shadow_prio[pos] >= c.task_priority) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_tag[i]  = shadow_tag[i-1];
        end
        shadow_prio[pos] = c.task_priority;
        shadow_tag[pos]  = c.task_tag;
        shadow_count++;
        r.status = ST_OK;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status       = ST_OK;
        r.out_tag      = shadow_tag[0];
        r.out_priority = shadow_prio[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_tag[i-1]  = shadow_tag[i];
        end
        shadow_count--;
      end
    end
    r.now_empty = (shadow_count == 0);
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", res_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          err_count++;
        end
        if (res_o.out_tag !== want.out_tag) begin
          $error("out_tag: expected %0d, got %0d", want.out_tag, res_o.out_tag);
          err_count++;
        end
        if (res_o.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, got %0d", want.out_priority,
                 res_o.out_priority);
          err_count++;
        end
        if (res_o.now_empty !== want.now_empty) begin
          $error("now_empty: expected %0d, got %0d", want.now_empty, res_o.now_empty);
          err_count++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      pending_results.push_back(apply_command(cmd_i));
    end
  end

  // 0: back to back, 1: short gaps, 2: mostly short with a few long ones
  function automatic int pick_gap(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) return (roll < 50) ? 0 : $urandom_range(1, 3);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t random_command(int enq_pct, bit tie_heavy);
    in_t c;
    logic [7:0] tie_set [4];
    tie_set = '{8'h00, 8'h07, 8'h80, 8'hFF};
    c.func     = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
    c.task_tag = 8'($urandom_range(0, 255));
    c.task_priority = tie_heavy ? tie_set[$urandom_range(0, 3)]
                                : 8'($urandom_range(0, 255));
    return c;
  endfunction

  // hold start low for gap cycles, then present the word until it is taken
  task automatic send_word(in_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      cmd_i <= in_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic test_empty_dequeue();
    in_t c;
    c = '{func: FUNC_DEQ, task_tag: 8'hFF, task_priority: 8'hFF};
    send_word(c, 0);
    send_word(c, 2);
  endtask

  // ties at the top, bottom and middle check arrival order among equals
  task automatic test_fill_to_full();
    logic [7:0] fill_prio [16];
    in_t c;
    fill_prio = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h7F, 8'h81,
                  8'h80, 8'h01, 8'hFE, 8'h80, 8'h00, 8'hFF, 8'h55, 8'hAA};
    for (int i = 0; i < DEPTH; i++) begin
      c.func          = FUNC_ENQ;
      c.task_tag      = 8'(i * 17);
      c.task_priority = fill_prio[i];
      send_word(c, pick_gap(i % 3));
    end
  endtask

  task automatic test_overflow();
    send_word('{func: FUNC_ENQ, task_tag: 8'hFF, task_priority: 8'hFF}, 0);
    send_word('{func: FUNC_ENQ, task_tag: 8'h00, task_priority: 8'h00}, 1);
  endtask

  task automatic test_partial_drain();
    for (int i = 0; i < 4; i++)
      send_word('{func: FUNC_DEQ, task_tag: 8'($urandom), task_priority: 8'($urandom)},
                pick_gap(2));
  endtask

  // bursts alternate between filling, draining and balanced traffic
  task automatic test_random_traffic();
    int enq_bias [10];
    enq_bias = '{85, 20, 50, 95, 10, 60, 40, 80, 30, 50};
    for (int r = 0; r < 10; r++) begin
      for (int n = 0; n < 125; n++)
        send_word(random_command(enq_bias[r], r[0]), pick_gap(r % 3));
    end
  endtask

  task automatic finish_run();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      err_count++;
    end
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("sorted_priority_queue verification clean");
    end else begin
      $display("sorted_priority_queue verification failed");
    end
    $finish;
  endtask

  initial begin
    start        = 1'b0;
    cmd_i        = '0;
    rst_ni       = 1'b0;
    shadow_count = 0;
    err_count    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_dequeue();
    test_fill_to_full();
    test_overflow();
    test_partial_drain();
    test_random_traffic();
    finish_run();
  end

  initial begin
    #5_000_000;
    $display("sorted_priority_queue verification failed");
    $finish;
  end

endmodule
